FILE: rtl/core/fdl_pkg.sv
package fdl_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MAX_CLUSTERS = 256;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = 11;
  localparam int RIN_W  = ROW_W + 1;
  localparam int CNT_W  = $clog2(MAX_CLUSTERS) + 1;
  localparam int LBL_W  = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  localparam logic OP_CELL = 1'b0;
  localparam logic OP_PAD  = 1'b1;

  localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;
  localparam logic signed [7:0] OCC_FREE    = 8'sd0;

  typedef enum logic [1:0] {
    CLS_OCC  = 2'd0,
    CLS_FREE = 2'd1,
    CLS_UNK  = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t r1;
    cls_t r2;
  } hist_t;

  typedef struct packed {
    cls_t t;
    cls_t m;
    cls_t b;
  } col_t;

  typedef struct packed {
    logic             valid;
    logic [LBL_W-1:0] lbl;
  } lbl_t;

  typedef struct packed {
    cls_t             cls;
    logic [COL_W-1:0] cin;
    logic             decide;
    logic [ROW_W-1:0] qr;
    logic [COL_W-1:0] qc;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             valid_res;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             is_frontier;
    logic [LBL_W-1:0] cluster;
    logic             new_cluster;
    logic             overflow;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] cluster_count;
    logic [1:0]       oq_count;
  } stat_t;

endpackage

FILE: rtl/core/frontier_detect_and_label.sv
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+----------------------
// input    | in_operation, in_occupancy              | in_push / in_full
// result   | out_valid_res .. out_overflow           | out_empty / out_pop
// config   | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// one word in and one word out per cycle while results are popped; each result is
// registered in the input queue, the back end stage and the result queue before it
// leaves the core. a result word appears map_width+1 input words after its cell.
// rst_n is synchronous; line buffer contents are not cleared.
// a full result queue stalls the back end, which then fills the 2-entry
// queue between front and back and raises in_full.
module frontier_detect_and_label (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_operation,
  input  logic signed [7:0]             in_occupancy,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_valid_res,
  output logic [fdl_pkg::ROW_W-1:0]     out_row,
  output logic [fdl_pkg::COL_W-1:0]     out_col,
  output logic                          out_is_frontier,
  output logic [fdl_pkg::LBL_W-1:0]     out_cluster,
  output logic                          out_new_cluster,
  output logic                          out_overflow,
  input  logic                          cfg_we,
  input  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdl_pkg::DIM_W-1:0]     cfg_wdata
);
  import fdl_pkg::*;

  logic [DIM_W-1:0] map_width_r, map_height_r;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             q_push, q_full, q_pop, q_empty;
  item_t            q_item, q_head;
  res_t             res;
  stat_t            stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= DIM_W'(1);
      map_height_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
        REG_MAP_HEIGHT: map_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (map_width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = map_width_r;
    end
    if (map_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (map_height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = map_height_r;
    end
  end

  assign in_full = q_full;

  fdl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_operation (in_operation),
    .in_occupancy (in_occupancy),
    .q_full       (q_full),
    .w            (w_eff),
    .h            (h_eff),
    .cfg_clr      (cfg_we),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  fdl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  fdl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .w         (w_eff),
    .h         (h_eff),
    .cfg_clr   (cfg_we),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res       (res),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .stat      (stat)
  );

  assign out_valid_res   = res.valid_res;
  assign out_row         = res.row;
  assign out_col         = res.col;
  assign out_is_frontier = res.is_frontier;
  assign out_cluster     = res.cluster;
  assign out_new_cluster = res.new_cluster;
  assign out_overflow    = res.overflow;

`ifndef SYNTHESIS
  a_cfg_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> stat.cluster_count == '0)
    else $error("cluster count not cleared by register write");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cluster_count <= CNT_W'(MAX_CLUSTERS))
    else $error("cluster count beyond label space");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.oq_count <= 2'd2 && (out_empty == (stat.oq_count == 2'd0)))
    else $error("result queue count inconsistent");
`endif

endmodule

FILE: rtl/core/fdl_front.sv
module fdl_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic                      in_operation,
  input  logic signed [7:0]         in_occupancy,
  input  logic                      q_full,
  input  logic [fdl_pkg::DIM_W-1:0] w,
  input  logic [fdl_pkg::DIM_W-1:0] h,
  input  logic                      cfg_clr,
  output logic                      q_push,
  output fdl_pkg::item_t            q_item
);
  import fdl_pkg::*;

  logic [RIN_W-1:0] rin_r, rin_nxt;
  logic [COL_W-1:0] cin_r, cin_nxt;
  logic [ROW_W-1:0] qr_r, qr_nxt;
  logic [COL_W-1:0] qc_r, qc_nxt;
  logic             decide;
  logic             last;
  logic             real_cell;
  cls_t             cls;
  logic [DIM_W-1:0] cin_inc;
  logic [DIM_W-1:0] qc_inc;

  assign q_push = in_push && !q_full;

  always_comb begin
    decide    = (rin_r >= RIN_W'(2)) || ((rin_r == RIN_W'(1)) && (cin_r != '0));
    last      = (DIM_W'(rin_r) == h + DIM_W'(1)) && (cin_r == '0);
    real_cell = (DIM_W'(rin_r) < h) && (in_operation == OP_CELL);
    cls = CLS_OCC;
    if (real_cell) begin
      if (in_occupancy == OCC_UNKNOWN) begin
        cls = CLS_UNK;
      end else if (in_occupancy == OCC_FREE) begin
        cls = CLS_FREE;
      end
    end
    cin_inc = DIM_W'(cin_r) + DIM_W'(1);
    qc_inc  = DIM_W'(qc_r) + DIM_W'(1);

    rin_nxt = rin_r;
    cin_nxt = cin_r;
    qr_nxt  = qr_r;
    qc_nxt  = qc_r;
    if (q_push) begin
      if (last) begin
        rin_nxt = '0;
        cin_nxt = '0;
        qr_nxt  = '0;
        qc_nxt  = '0;
      end else begin
        if (cin_inc == w) begin
          cin_nxt = '0;
          rin_nxt = rin_r + RIN_W'(1);
        end else begin
          cin_nxt = cin_inc[COL_W-1:0];
        end
        if (decide) begin
          if (qc_inc == w) begin
            qc_nxt = '0;
            qr_nxt = qr_r + ROW_W'(1);
          end else begin
            qc_nxt = qc_inc[COL_W-1:0];
          end
        end
      end
    end

    q_item.cls    = cls;
    q_item.cin    = cin_r;
    q_item.decide = decide;
    q_item.qr     = qr_r;
    q_item.qc     = qc_r;
    q_item.last   = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clr) begin
      rin_r <= '0;
      cin_r <= '0;
      qr_r  <= '0;
      qc_r  <= '0;
    end else begin
      rin_r <= rin_nxt;
      cin_r <= cin_nxt;
      qr_r  <= qr_nxt;
      qc_r  <= qc_nxt;
    end
  end

endmodule

FILE: rtl/core/fdl_queue.sv
module fdl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fdl_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output fdl_pkg::item_t dout,
  output logic           empty
);
  import fdl_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/fdl_back.sv
module fdl_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fdl_pkg::DIM_W-1:0] w,
  input  logic [fdl_pkg::DIM_W-1:0] h,
  input  logic                      cfg_clr,
  input  logic                      q_empty,
  input  fdl_pkg::item_t            q_head,
  output logic                      q_pop,
  output fdl_pkg::res_t             res,
  output logic                      res_empty,
  input  logic                      res_pop,
  output fdl_pkg::stat_t            stat
);
  import fdl_pkg::*;

  // line buffers
  hist_t cmem [MAX_WIDTH];
  lbl_t  lmem [MAX_WIDTH];

  logic             s1_valid_r;
  item_t            s1_r;
  hist_t            hist_rd_r;
  lbl_t             lbl_rd_r;
  col_t             col_l_r, col_m_r;
  lbl_t             prev_tr_r, last_lbl_r, window_r;
  logic [CNT_W-1:0] cnt_r;

  res_t             oq_r [2];
  logic             oq_wp_r, oq_rp_r;
  logic [1:0]       oq_cnt_r;

  logic             exec, load;
  logic [DIM_W-1:0] lrd_inc;
  logic [COL_W-1:0] lrd_addr;
  col_t             col_n;
  hist_t            hist_new;
  logic             top_ok, bot_ok, left_ok, right_ok;
  logic             any_unk, frontier;
  lbl_t             top_raw, tl, top, left, tr, newlbl;
  logic             opened, ovf;
  res_t             r_new;

  assign exec  = s1_valid_r && (oq_cnt_r != 2'd2);
  assign load  = !q_empty && (!s1_valid_r || exec);
  assign q_pop = load;

  always_comb begin
    lrd_inc  = DIM_W'(q_head.qc) + DIM_W'(1);
    lrd_addr = (lrd_inc == w) ? '0 : lrd_inc[COL_W-1:0];
  end

  always_comb begin
    col_n.t = hist_rd_r.r2;
    col_n.m = hist_rd_r.r1;
    col_n.b = s1_r.cls;
    hist_new.r1 = s1_r.cls;
    hist_new.r2 = hist_rd_r.r1;

    top_ok   = (s1_r.qr != '0);
    bot_ok   = (DIM_W'(s1_r.qr) + DIM_W'(1)) < h;
    left_ok  = (s1_r.qc != '0);
    right_ok = (DIM_W'(s1_r.qc) + DIM_W'(1)) < w;

    any_unk = (top_ok && left_ok && col_l_r.t == CLS_UNK)
           || (top_ok && col_m_r.t == CLS_UNK)
           || (top_ok && right_ok && col_n.t == CLS_UNK)
           || (left_ok && col_l_r.m == CLS_UNK)
           || (right_ok && col_n.m == CLS_UNK)
           || (bot_ok && left_ok && col_l_r.b == CLS_UNK)
           || (bot_ok && col_m_r.b == CLS_UNK)
           || (bot_ok && right_ok && col_n.b == CLS_UNK);
    frontier = s1_r.decide && (col_m_r.m == CLS_FREE) && any_unk;

    // single column map: the fresh read already holds the label above
    top_raw = (w == DIM_W'(1)) ? lbl_rd_r : prev_tr_r;
    tl   = (top_ok && left_ok) ? window_r : '0;
    top  = top_ok ? top_raw : '0;
    left = left_ok ? last_lbl_r : '0;
    tr   = (top_ok && right_ok) ? lbl_rd_r : '0;

    newlbl = '0;
    opened = 1'b0;
    ovf    = 1'b0;
    if (frontier) begin
      if (tl.valid) begin
        newlbl = tl;
      end else if (top.valid) begin
        newlbl = top;
      end else if (left.valid) begin
        newlbl = left;
      end else if (tr.valid) begin
        newlbl = tr;
      end else if (cnt_r < CNT_W'(MAX_CLUSTERS)) begin
        newlbl.valid = 1'b1;
        newlbl.lbl   = cnt_r[LBL_W-1:0];
        opened       = 1'b1;
      end else begin
        ovf = 1'b1;
      end
    end

    r_new.valid_res   = s1_r.decide;
    r_new.row         = s1_r.decide ? s1_r.qr : '0;
    r_new.col         = s1_r.decide ? s1_r.qc : '0;
    r_new.is_frontier = frontier;
    r_new.cluster     = newlbl.valid ? newlbl.lbl : '0;
    r_new.new_cluster = opened;
    r_new.overflow    = ovf;
  end

  // read port with bypass of the word written in the same cycle
  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= q_head;
      if (exec && s1_r.cin == q_head.cin) begin
        hist_rd_r <= hist_new;
      end else begin
        hist_rd_r <= cmem[q_head.cin];
      end
      if (exec && s1_r.decide && s1_r.qc == lrd_addr) begin
        lbl_rd_r <= newlbl;
      end else begin
        lbl_rd_r <= lmem[lrd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      cmem[s1_r.cin] <= hist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && s1_r.decide) begin
      lmem[s1_r.qc] <= newlbl;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      col_l_r <= col_m_r;
      col_m_r <= col_n;
      if (s1_r.decide) begin
        window_r   <= top_raw;
        prev_tr_r  <= lbl_rd_r;
        last_lbl_r <= newlbl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (exec) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_clr) begin
        cnt_r <= '0;
      end else if (exec && s1_r.last) begin
        cnt_r <= '0;
      end else if (exec && opened) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // result queue
  logic oq_pop;
  assign oq_pop    = res_pop && (oq_cnt_r != 2'd0);
  assign res_empty = (oq_cnt_r == 2'd0);
  assign res       = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (exec) begin
      oq_r[oq_wp_r] <= r_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (exec) begin
        oq_wp_r <= !oq_wp_r;
      end
      if (oq_pop) begin
        oq_rp_r <= !oq_rp_r;
      end
      if (exec && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 2'd1;
      end else if (!exec && oq_pop) begin
        oq_cnt_r <= oq_cnt_r - 2'd1;
      end
    end
  end

  assign stat.cluster_count = cnt_r;
  assign stat.oq_count      = oq_cnt_r;

endmodule

FILE: dv/tb_frontier_detect_and_label.sv
module tb_frontier_detect_and_label;
  import fdl_pkg::*;

  localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_operation = OP_CELL;
  logic signed [7:0] in_occupancy = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_valid_res;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic out_is_frontier;
  logic [LBL_W-1:0] out_cluster;
  logic out_new_cluster;
  logic out_overflow;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAP_WIDTH;
  logic [DIM_W-1:0] cfg_wdata = '0;

  frontier_detect_and_label u_dut (.*);

  always #6 clk = ~clk;

  // predictor state
  cls_t cls_hist [HIST_DEPTH];
  logic [8:0] col_label [MAX_WIDTH];
  logic [8:0] above_left = '0;
  int frame_pos = 0;
  int clusters_used = 0;
  logic [DIM_W-1:0] map_w = 1;
  logic [DIM_W-1:0] map_h = 1;

  res_t expected_words [$];
  int errors = 0;
  int words_sent = 0;
  int cycles = 0;
  int pop_hold = 0;
  bit quiet = 1'b0;

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  task automatic predict_word(logic op, logic signed [7:0] occ);
    int w, h, cells, flen, p, q, r, c, dr, dc, nb;
    cls_t cl;
    res_t e;
    logic fr;
    logic [8:0] tl, tp, lf, trr, nl;
    w = clamp_dim(map_w, MAX_WIDTH);
    h = clamp_dim(map_h, MAX_HEIGHT);
    cells = w * h;
    flen = cells + w + 1;
    p = frame_pos;
    cl = CLS_OCC;
    if (op == OP_CELL && p < cells) begin
      if (occ == OCC_UNKNOWN) cl = CLS_UNK;
      else if (occ == OCC_FREE) cl = CLS_FREE;
    end
    cls_hist[p % HIST_DEPTH] = cl;
    e = '0;
    if (p >= w + 1) begin
      q = p - w - 1;
      r = q / w;
      c = q % w;
      fr = 1'b0;
      nl = '0;
      if (cls_hist[q % HIST_DEPTH] == CLS_FREE) begin
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            if ((dr < 0 && r == 0) || (dr > 0 && r + 1 >= h) ||
                (dc < 0 && c == 0) || (dc > 0 && c + 1 >= w)) continue;
            nb = q + dr * w + dc;
            if (cls_hist[nb % HIST_DEPTH] == CLS_UNK) fr = 1'b1;
          end
        end
      end
      e.valid_res = 1'b1;
      e.row = ROW_W'(r);
      e.col = COL_W'(c);
      if (fr) begin
        tl = (r > 0 && c > 0) ? above_left : '0;
        tp = (r > 0) ? col_label[c] : '0;
        lf = (c > 0) ? col_label[c-1] : '0;
        trr = (r > 0 && c + 1 < w) ? col_label[c+1] : '0;
        e.is_frontier = 1'b1;
        if (tl[8]) nl = tl;
        else if (tp[8]) nl = tp;
        else if (lf[8]) nl = lf;
        else if (trr[8]) nl = trr;
        else if (clusters_used < MAX_CLUSTERS) begin
          nl = {1'b1, 8'(clusters_used)};
          clusters_used++;
          e.new_cluster = 1'b1;
        end else begin
          e.overflow = 1'b1;
        end
        if (nl[8]) e.cluster = nl[7:0];
      end
      above_left = col_label[c];
      col_label[c] = nl;
    end
    p++;
    if (p >= flen) begin
      p = 0;
      clusters_used = 0;
    end
    frame_pos = p;
    expected_words.insert(expected_words.size(), e);
  endtask

  task automatic send_word(logic op, logic signed [7:0] occ);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 7);
      @(negedge clk);
      in_push <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_operation <= op;
    in_occupancy <= occ;
    do @(posedge clk); while (in_full);
    predict_word(op, occ);
    words_sent++;
  endtask

  task automatic drain_all();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    drain_all();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAP_WIDTH) map_w = val;
    else map_h = val;
    frame_pos = 0;
    clusters_used = 0;
  endtask

  function automatic logic signed [7:0] rand_occ();
    case ($urandom_range(0, 7))
      0, 1, 2: return OCC_UNKNOWN;
      3, 4, 5: return OCC_FREE;
      6: return 8'($urandom_range(1, 100));
      default: return 8'($urandom);
    endcase
  endfunction

  // cells then pads; noise puts early pads and late cells in
  task automatic run_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, bit noisy, bit cut);
    int ew, eh, i, stop;
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    ew = clamp_dim(w, MAX_WIDTH);
    eh = clamp_dim(h, MAX_HEIGHT);
    stop = cut ? $urandom_range(0, ew * eh + ew) : ew * eh + ew + 1;
    for (i = 0; i < ew * eh + ew + 1 && i < stop; i++) begin
      if (i < ew * eh)
        send_word((noisy && $urandom_range(0, 30) == 0) ? OP_PAD : OP_CELL, rand_occ());
      else
        send_word((noisy && $urandom_range(0, 20) == 0) ? OP_CELL : OP_PAD, rand_occ());
    end
  endtask

  task automatic test_reset_defaults();
    send_word(OP_CELL, OCC_FREE);
    send_word(OP_PAD, 8'sd0);
    send_word(OP_PAD, 8'sd0);
    send_word(OP_CELL, OCC_UNKNOWN);
    send_word(OP_PAD, 8'sd0);
    send_word(OP_CELL, 8'sd55);
  endtask

  task automatic test_small_map();
    write_reg(REG_MAP_WIDTH, DIM_W'(3));
    write_reg(REG_MAP_HEIGHT, DIM_W'(3));
    send_word(OP_CELL, OCC_FREE);
    send_word(OP_CELL, OCC_UNKNOWN);
    send_word(OP_CELL, OCC_FREE);
    send_word(OP_CELL, 8'sd100);
    send_word(OP_PAD, OCC_FREE);
    send_word(OP_CELL, -8'sd128);
    send_word(OP_CELL, OCC_FREE);
    send_word(OP_CELL, 8'sd127);
    send_word(OP_CELL, OCC_FREE);
    send_word(OP_PAD, 8'sd0);
    send_word(OP_CELL, OCC_UNKNOWN);
    send_word(OP_PAD, 8'sd0);
    send_word(OP_PAD, 8'sd0);
  endtask

  task automatic test_dim_extremes();
    run_frame(DIM_W'(0), DIM_W'(0), 1'b0, 1'b0);
    run_frame(DIM_W'(5), DIM_W'(0), 1'b1, 1'b0);
    run_frame(DIM_W'(0), DIM_W'(5), 1'b1, 1'b1);
  endtask

  // single column of alternating free and unknown rows, height saturated
  task automatic test_overflow();
    int i;
    write_reg(REG_MAP_WIDTH, DIM_W'(0));
    write_reg(REG_MAP_HEIGHT, DIM_W'(2047));
    for (i = 0; i < MAX_HEIGHT; i++)
      send_word(OP_CELL, (i % 2 == 0) ? OCC_FREE : OCC_UNKNOWN);
    for (i = 0; i < 2; i++) send_word(OP_PAD, 8'sd0);
  endtask

  task automatic test_random_frames();
    int start;
    start = words_sent;
    while (words_sent - start < 600) begin
      if (words_sent - start > 450) quiet = 1'b1;
      if ($urandom_range(0, 5) == 0)
        run_frame(DIM_W'($urandom_range(1, 40)), DIM_W'($urandom_range(1, 6)), 1'b1,
                  $urandom_range(0, 3) == 0);
      else
        run_frame(DIM_W'($urandom_range(1, 12)), DIM_W'($urandom_range(1, 12)), 1'b1,
                  $urandom_range(0, 7) == 0);
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_pop <= 1'b0;
      pop_hold = $urandom_range(0, 6);
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual row %0d col %0d",
                 $time, out_row, out_col);
        errors++;
      end else begin
        e = expected_words.pop_front();
        check_field("valid_res", e.valid_res, out_valid_res);
        check_field("row", e.row, out_row);
        check_field("col", e.col, out_col);
        check_field("is_frontier", e.is_frontier, out_is_frontier);
        check_field("cluster", e.cluster, out_cluster);
        check_field("new_cluster", e.new_cluster, out_new_cluster);
        check_field("overflow", e.overflow, out_overflow);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_small_map();
    test_dim_extremes();
    test_overflow();
    test_random_frames();
    drain_all();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: frontier_detect_and_label.f
rtl/core/fdl_pkg.sv
rtl/core/fdl_front.sv
rtl/core/fdl_queue.sv
rtl/core/fdl_back.sv
rtl/core/frontier_detect_and_label.sv
dv/tb_frontier_detect_and_label.sv
